// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define PSP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define PSP_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/psp_pkg.sv =====
package psp_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TAG_W         = 64 - IDX_W;

    // page geometry
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = 64 - PAGE_SHIFT;

    // confidence counter
    localparam logic [1:0] CONF_MAX = 2'd3;

    // line size register reset value
    localparam logic [3:0] LINE_SHIFT_RESET = 4'd6;

    // front to back queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // input transfer
    typedef struct packed {
        logic [63:0] access_pc;
        logic [63:0] access_address;
        logic        is_hw_prefetch;
    } psp_in_t;

    // result transfer
    typedef struct packed {
        logic        issue_prefetch;
        logic [63:0] prefetch_address;
    } psp_out_t;

    // classified access travelling from front to back
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [TAG_W-1:0]  tag;
        logic [63:0]       line;
        logic [PAGE_W-1:0] page;
        logic              hw;
    } psp_item_t;

    // one table entry
    typedef struct packed {
        logic [TAG_W-1:0] pc_tag;
        logic [63:0]      prev_line;
        logic [63:0]      stride;
        logic [1:0]       confidence;
    } psp_entry_t;

    // queue status seen by the front end and the back end
    typedef struct packed {
        logic full;
        logic not_empty;
    } psp_qstat_t;

endpackage

// ===== hdl/psp_front.sv =====
module psp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  psp_pkg::psp_in_t  req,
    input  logic [3:0]        line_shift,
    input  psp_pkg::psp_qstat_t qstat,
    output logic              busy,
    output logic              push,
    output psp_pkg::psp_item_t push_item
);
    import psp_pkg::*;

    logic      fe_valid_reg;
    logic      fe_valid_next;
    psp_item_t fe_item_reg;
    psp_item_t fe_item_next;
    logic      accept;

    // handshake: hold off only when the stage is loaded and the queue is full
    always_comb
    begin
        busy   = fe_valid_reg & qstat.full;
        push   = fe_valid_reg & ~qstat.full;
        accept = start & ~busy;
    end

    // classify the access: table index, tag, line number, page
    always_comb
    begin
        fe_item_next.idx  = req.access_pc[IDX_W-1:0];
        fe_item_next.tag  = req.access_pc[63:IDX_W];
        fe_item_next.line = req.access_address >> line_shift;
        fe_item_next.page = req.access_address[63:PAGE_SHIFT];
        fe_item_next.hw   = req.is_hw_prefetch;
    end

    always_comb
    begin
        if (accept)
        begin
            fe_valid_next = 1'b1;
        end
        else if (push)
        begin
            fe_valid_next = 1'b0;
        end
        else
        begin
            fe_valid_next = fe_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else
        begin
            fe_valid_reg <= fe_valid_next;
        end
    end

    // payload stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fe_item_reg <= fe_item_next;
        end
    end

    assign push_item = fe_item_reg;

endmodule

// ===== hdl/psp_queue.sv =====
module psp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  psp_pkg::psp_item_t push_item,
    input  logic               pop,
    output psp_pkg::psp_item_t head_item,
    output psp_pkg::psp_qstat_t qstat
);
    import psp_pkg::*;

    psp_item_t        slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // status
    always_comb
    begin
        qstat.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
        qstat.not_empty = (count_reg != '0);
    end

    assign head_item = slot_mem[rd_ptr_reg];

    // pointer and fill count update, pointers wrap on the power-of-two depth
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/psp_back.sv =====
module psp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          line_shift,
    input  psp_pkg::psp_qstat_t qstat,
    input  psp_pkg::psp_item_t  head_item,
    output logic                pop,
    output logic                done,
    output psp_pkg::psp_out_t   result
);
    import psp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_TGT  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // stride table and its valid bits
    psp_entry_t               tbl_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;

    // item under work
    psp_item_t  item_reg;
    psp_entry_t rd_entry_reg;
    logic       rd_valid_reg;
    logic       go_reg;
    logic       go_next;
    logic [63:0] stride_reg;
    logic [63:0] stride_next;
    logic       go2_reg;
    logic [63:0] tline_reg;

    logic       hit;
    logic [63:0] delta;
    logic       same_stride;
    logic [1:0] conf_next;
    psp_entry_t wr_entry;
    logic       tbl_wr;
    logic [63:0] target;
    logic       issue;

    assign pop = ((state_reg == S_IDLE) || (state_reg == S_OUT)) && qstat.not_empty;

    // sequencer: read, update, target add, result
    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = pop ? S_UPD : S_IDLE;
            S_UPD:   state_next = S_TGT;
            S_TGT:   state_next = S_OUT;
            S_OUT:   state_next = pop ? S_UPD : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // entry update from the registered table read
    always_comb
    begin
        hit         = rd_valid_reg && (rd_entry_reg.pc_tag == item_reg.tag);
        delta       = item_reg.line - rd_entry_reg.prev_line;
        same_stride = (delta == rd_entry_reg.stride) && (delta != '0);
        conf_next   = 2'd0;
        stride_next = 64'd0;
        if (hit)
        begin
            if (same_stride)
            begin
                stride_next = rd_entry_reg.stride;
                conf_next   = (rd_entry_reg.confidence < CONF_MAX)
                              ? rd_entry_reg.confidence + 2'd1
                              : rd_entry_reg.confidence;
            end
            else
            begin
                stride_next = delta;
            end
        end
        go_next             = hit && (conf_next != 2'd0) && !item_reg.hw;
        wr_entry.pc_tag     = item_reg.tag;
        wr_entry.prev_line  = item_reg.line;
        wr_entry.stride     = stride_next;
        wr_entry.confidence = conf_next;
        tbl_wr              = (state_reg == S_UPD) && !item_reg.hw;
        valid_next          = valid_reg;
        if (tbl_wr)
        begin
            valid_next[item_reg.idx] = 1'b1;
        end
    end

    // target line check: non-negative and in the demand's page
    always_comb
    begin
        target = tline_reg << line_shift;
        issue  = go2_reg && !tline_reg[63] && (target[63:PAGE_SHIFT] == item_reg.page);
        done                    = (state_reg == S_OUT);
        result.issue_prefetch   = issue;
        result.prefetch_address = issue ? target : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // table read on pop, write in the update step
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg     <= head_item;
            rd_entry_reg <= tbl_mem[head_item.idx];
            rd_valid_reg <= valid_reg[head_item.idx];
        end
        if (tbl_wr)
        begin
            tbl_mem[item_reg.idx] <= wr_entry;
        end
    end

    // update and target pipeline payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            go_reg     <= go_next;
            stride_reg <= stride_next;
        end
        if (state_reg == S_TGT)
        begin
            go2_reg   <= go_reg;
            tline_reg <= item_reg.line + stride_reg;
        end
    end

endmodule

// ===== hdl/pc_stride_prefetcher.sv =====
// PC-indexed stride prefetcher.
// Input: an access transfer (req) is taken at a clock edge where start is high
// and busy is low. Access flagged as hardware prefetches give a result with
// issue_prefetch low and leave the table unchanged.
// Output: every access gives exactly one result, shown on result for one cycle
// with done high; the receiver cannot stall, so results are never held back.
// Configuration: cfg_wr_en with cfg_wr_data writes line_shift (log2 of the line
// size), taken at the edge where cfg_wr_en is high; reset value 6.
// Path: from the accept edge through the front stage, queue, table read, entry
// update and target add, to the page check in the cycle with done high.
// The back end reads the single-ported 256-entry table, writes the entry back
// and forms the target before it takes the next access. A 2-deep queue
// between front and back absorbs short bursts; busy rises when front stage
// and queue are full.
// Reset: all table entries become invalid at once, the queue empties and
// line_shift returns to 6; the block accepts an access in the first cycle.
module pc_stride_prefetcher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  psp_pkg::psp_in_t  req,
    output logic              done,
    output psp_pkg::psp_out_t result,
    input  logic              cfg_wr_en,
    input  logic [3:0]        cfg_wr_data
);
    import psp_pkg::*;

    logic       [3:0] line_shift_reg;
    logic             push;
    logic             pop;
    psp_item_t        push_item;
    psp_item_t        head_item;
    psp_qstat_t       qstat;

    // line size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_shift_reg <= LINE_SHIFT_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_shift_reg <= cfg_wr_data;
        end
    end

    // accept and classify
    psp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .line_shift (line_shift_reg),
        .qstat      (qstat),
        .busy       (busy),
        .push       (push),
        .push_item  (push_item)
    );

    // decoupling queue
    psp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .qstat      (qstat)
    );

    // table lookup, update and prefetch decision
    psp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_shift (line_shift_reg),
        .qstat      (qstat),
        .head_item  (head_item),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

    `include "assert_macros.svh"

    // done never stays high in the cycle after a result
    `PSP_ASSERT(a_done_spaced, done |=> !done, "back-to-back results")
    // an issued prefetch is aligned to the configured line size
    `PSP_ASSERT(a_issue_aligned, (done && result.issue_prefetch) |-> ((result.prefetch_address & ((64'd1 << line_shift_reg) - 64'd1)) == 64'd0), "prefetch address not line aligned")
    // the queue never takes a transfer while full and never pops while empty
    `PSP_NEVER(a_queue_overflow, (push && qstat.full && !pop) || (pop && !qstat.not_empty), "queue overflow or underflow")

endmodule

// ===== tb/tb_pc_stride_prefetcher.sv =====
`timescale 1ns / 1ps

module tb_pc_stride_prefetcher;

    import psp_pkg::*;

    localparam int NUM_PHASES      = 10;
    localparam int PHASE_ACCESSES  = 190;
    localparam int NUM_STREAMS     = 8;
    localparam int IDLE_PCT        = 37;
    localparam int SETTLE_CYCLES   = 20;
    localparam longint TIMEOUT_NS  = 3_000_000;

    // directed stimulus row, expectation typed in where it is obvious
    typedef struct packed {
        logic [63:0] pc;
        logic [63:0] addr;
        logic        hw;
        logic        typed;
        logic        exp_issue;
        logic [63:0] exp_addr;
    } stim_row_t;

    localparam int NUM_ROWS = 21;
    localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
        // first access after reset misses
        '{64'h400, 64'h1000, 1'b0, 1'b1, 1'b0, 64'h0},
        // stride of one line builds up and saturates
        '{64'h400, 64'h1040, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'h400, 64'h1080, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'h400, 64'h10c0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'h400, 64'h1100, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'h400, 64'h1140, 1'b0, 1'b0, 1'b0, 64'h0},
        // hardware prefetch is ignored
        '{64'h400, 64'h1180, 1'b1, 1'b1, 1'b0, 64'h0},
        '{64'h400, 64'h1180, 1'b0, 1'b0, 1'b0, 64'h0},
        // zero delta clears confidence
        '{64'h400, 64'h1180, 1'b0, 1'b0, 1'b0, 64'h0},
        // target crosses into the next page
        '{64'h500, 64'h1f40, 1'b0, 1'b1, 1'b0, 64'h0},
        '{64'h500, 64'h1f80, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'h500, 64'h1fc0, 1'b0, 1'b0, 1'b0, 64'h0},
        // descending stride wraps below line zero
        '{64'h600, 64'h80, 1'b0, 1'b1, 1'b0, 64'h0},
        '{64'h600, 64'h40, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'h600, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0},
        // all ones pc and address, descending
        '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 1'b0, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffbf, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ff7f, 1'b0, 1'b0, 1'b0, 64'h0},
        // index conflict reallocates the entry
        '{64'h0, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0},
        '{64'h400, 64'h1200, 1'b0, 1'b1, 1'b0, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b0, 64'h0}
    };

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    psp_in_t  req;
    logic     done;
    psp_out_t result;
    logic     cfg_wr_en;
    logic [3:0] cfg_wr_data;

    // predictor state
    logic             tbl_valid     [TABLE_ENTRIES];
    logic [TAG_W-1:0] tbl_tag       [TABLE_ENTRIES];
    logic [63:0]      tbl_prev_line [TABLE_ENTRIES];
    logic [63:0]      tbl_stride    [TABLE_ENTRIES];
    logic [1:0]       tbl_conf      [TABLE_ENTRIES];
    logic [3:0]       line_shift;

    psp_out_t pending_prefetch_q [$];
    int       mismatch_count;
    bit       idle_on;

    // access streams for the random part
    logic [63:0]        stream_pc   [NUM_STREAMS];
    logic [63:0]        stream_addr [NUM_STREAMS];
    logic signed [63:0] stream_step [NUM_STREAMS];

    pc_stride_prefetcher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("[pc_stride_prefetcher] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // expected result of one access, updates the predicted table
    function automatic psp_out_t predict_prefetch(input psp_in_t a);
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tag;
        logic [63:0]      line;
        logic [63:0]      delta;
        logic [63:0]      tline;
        logic [63:0]      target;
        psp_out_t         r;
        r = '0;
        if (a.is_hw_prefetch)
            return r;
        idx  = a.access_pc[IDX_W-1:0];
        tag  = a.access_pc[63:IDX_W];
        line = a.access_address >> line_shift;
        if (tbl_valid[idx] && tbl_tag[idx] == tag)
        begin
            delta = line - tbl_prev_line[idx];
            if (delta == tbl_stride[idx] && delta != 64'd0)
            begin
                if (tbl_conf[idx] != CONF_MAX)
                    tbl_conf[idx] = tbl_conf[idx] + 2'd1;
            end
            else
            begin
                tbl_stride[idx] = delta;
                tbl_conf[idx]   = 2'd0;
            end
            if (tbl_conf[idx] != 2'd0)
            begin
                tline = line + tbl_stride[idx];
                if (!tline[63])
                begin
                    target = tline << line_shift;
                    if ((target >> PAGE_SHIFT) == (a.access_address >> PAGE_SHIFT))
                    begin
                        r.issue_prefetch   = 1'b1;
                        r.prefetch_address = target;
                    end
                end
            end
        end
        else
        begin
            tbl_valid[idx]  = 1'b1;
            tbl_tag[idx]    = tag;
            tbl_stride[idx] = 64'd0;
            tbl_conf[idx]   = 2'd0;
        end
        tbl_prev_line[idx] = line;
        return r;
    endfunction

    // result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        psp_out_t want;
        if (rst_n && done)
        begin
            if (pending_prefetch_q.size() == 0)
                report_mismatch("unexpected result", {63'd0, result.issue_prefetch}, 64'd0);
            else
            begin
                want = pending_prefetch_q.pop_front();
                if (result.issue_prefetch !== want.issue_prefetch)
                    report_mismatch("issue_prefetch", {63'd0, result.issue_prefetch},
                                    {63'd0, want.issue_prefetch});
                if (result.prefetch_address !== want.prefetch_address)
                    report_mismatch("prefetch_address", result.prefetch_address,
                                    want.prefetch_address);
            end
        end
    end

    // present one access and wait for its transfer; called at a falling edge
    task automatic send_access(input psp_in_t a, input bit use_typed, input psp_out_t typed);
        psp_out_t predicted;
        bit       taken;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= a;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken     = 1'b1;
                predicted = predict_prefetch(a);
                pending_prefetch_q.push_back(use_typed ? typed : predicted);
            end
            @(negedge clk);
        end
    endtask

    // stop sending and wait for every expected result
    task automatic drain_results();
        start <= 1'b0;
        while (pending_prefetch_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_line_shift(input logic [3:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        line_shift  = value;
    endtask

    // new base address for a stream, often near a boundary
    function automatic logic [63:0] pick_base();
        logic [63:0] base;
        base = {$urandom, $urandom};
        case ($urandom_range(4))
            0: ;
            1: base[11:0] = 12'hfff - 12'(64'($urandom_range(3)) << line_shift);
            2: base = 64'($urandom_range(255)) << line_shift;
            3: base = 64'h8000_0000_0000_0000 - (64'($urandom_range(8)) << line_shift);
            default: base = 64'hffff_ffff_ffff_ffff - (64'($urandom_range(8)) << line_shift);
        endcase
        return base;
    endfunction

    function automatic logic signed [63:0] pick_step();
        logic signed [63:0] lines;
        lines = 64'(signed'($urandom_range(8)) - 4);
        return lines <<< line_shift;
    endfunction

    // next random access: mostly strided streams, some noise and prefetches
    task automatic next_random_access(output psp_in_t a);
        int          pick;
        int          k;
        logic [63:0] line_mask;
        pick = $urandom_range(99);
        a    = '0;
        if (pick < 8)
        begin
            a.access_pc      = {$urandom, $urandom};
            a.access_address = {$urandom, $urandom};
            a.is_hw_prefetch = 1'b1;
        end
        else if (pick < 16)
        begin
            a.access_pc      = {$urandom, $urandom};
            a.access_address = {$urandom, $urandom};
        end
        else
        begin
            k = $urandom_range(NUM_STREAMS - 1);
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                stream_pc[k][63:IDX_W] = TAG_W'({$urandom, $urandom});
                stream_addr[k] = pick_base();
                stream_step[k] = pick_step();
            end
            else if (pick < 9)
                stream_step[k] = pick_step();
            if (pick < 95)
                stream_addr[k] = stream_addr[k] + stream_step[k];
            line_mask = (64'd1 << line_shift) - 64'd1;
            a.access_pc      = stream_pc[k];
            a.access_address = (stream_addr[k] & ~line_mask) | ({$urandom, $urandom} & line_mask);
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        psp_in_t    a;
        psp_out_t   typed;
        logic [3:0] phase_shift [NUM_PHASES];
        int         counted;

        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        line_shift     = LINE_SHIFT_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tbl_valid[i]     = 1'b0;
            tbl_tag[i]       = '0;
            tbl_prev_line[i] = '0;
            tbl_stride[i]    = '0;
            tbl_conf[i]      = '0;
        end
        for (int k = 0; k < NUM_STREAMS; k++)
        begin
            stream_pc[k]   = {$urandom, $urandom};
            // streams six and seven share a table entry with zero and one
            stream_pc[k][IDX_W-1:0] = IDX_W'(k % 6);
            stream_addr[k] = pick_base();
            stream_step[k] = pick_step();
        end
        phase_shift = '{4'd0, 4'd12, 4'd15, 4'd6, 4'd2, 4'd13, 4'd1, 4'd9, 4'd4, 4'd3};
        phase_shift[5] = 4'($urandom_range(15));
        phase_shift[8] = 4'($urandom_range(15));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows at the reset line size
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            a.access_pc            = STIM_ROWS[r].pc;
            a.access_address       = STIM_ROWS[r].addr;
            a.is_hw_prefetch       = STIM_ROWS[r].hw;
            typed.issue_prefetch   = STIM_ROWS[r].exp_issue;
            typed.prefetch_address = STIM_ROWS[r].exp_addr;
            send_access(a, STIM_ROWS[r].typed, typed);
        end

        // random phases, each at its own line size
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_line_shift(phase_shift[p]);
            idle_on = (p != 3);
            for (int k = 0; k < NUM_STREAMS; k++)
                stream_step[k] = pick_step();
            counted = 0;
            while (counted < PHASE_ACCESSES)
            begin
                next_random_access(a);
                send_access(a, 1'b0, '0);
                counted++;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[pc_stride_prefetcher] OK");
        else
            $display("[pc_stride_prefetcher] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/psp_pkg.sv
hdl/psp_front.sv
hdl/psp_queue.sv
hdl/psp_back.sv
hdl/pc_stride_prefetcher.sv
tb/tb_pc_stride_prefetcher.sv
